FILE: sv/sdcr_pkg.sv
// Shared types, register map and arithmetic helpers for the stereo comb reverb.
package sdcr_pkg;

    typedef logic signed [15:0] sample_t;
    typedef logic        [15:0] coef_t;

    localparam int unsigned CFG_ADDR_W = 4;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [1:0] REG_MIX_LEVEL     = 2'd0;
    localparam logic [1:0] REG_ROOM_FEEDBACK = 2'd1;
    localparam logic [1:0] REG_DAMPING       = 2'd2;

    localparam coef_t MIX_LEVEL_RESET     = 16'd26214;
    localparam coef_t ROOM_FEEDBACK_RESET = 16'd39322;
    localparam coef_t DAMPING_RESET       = 16'd19661;

    // Round a product scaled by 2^16 to the nearest integer, ties upward.
    function automatic logic signed [17:0] round16(input logic signed [33:0] x);
        logic signed [33:0] y;
        y = x + 34'sd32768;
        return y[33:16];
    endfunction

    // Add a rounded product to a sample and clamp to 16 bits.
    function automatic sample_t add_sat(input sample_t base, input logic signed [17:0] rnd);
        logic signed [18:0] s;
        s = {{3{base[15]}}, base} + {rnd[17], rnd};
        if (s > 19'sd32767) begin
            return 16'sh7fff;
        end else if (s < -19'sd32768) begin
            return 16'sh8000;
        end else begin
            return s[15:0];
        end
    endfunction

endpackage

FILE: sv/stereo_damped_comb_reverb.sv
// Stereo damped comb reverb: shared multiplier under a sequencer, one delay line per channel.
// Per accepted input beat the sequencer runs ST_RD_FAR, six multiply states and ST_FIN;
// ST_FIN, held by a stalled output, raises m_tvalid; a new pair is taken only in ST_IDLE.
// The single 17x17 multiplier serves all six coefficient products in turn.
// Reset: registers return to their defaults, the write position and fill count go to zero.
// Delay entries not yet written read as zero through the fill count; no clearing pass.
module stereo_damped_comb_reverb
    import sdcr_pkg::*;
#(
    parameter int unsigned DELAY_LENGTH = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] left_in, [31:16] right_in
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [31:0]           m_tdata,   // [15:0] left_out, [31:16] right_out
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int unsigned AW   = $clog2(DELAY_LENGTH);
    localparam int unsigned HALF = DELAY_LENGTH / 2;
    localparam logic [AW:0] LEN_W  = (AW+1)'(DELAY_LENGTH);
    localparam logic [AW:0] HALF_W = (AW+1)'(HALF);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_RD_FAR,
        ST_MUL_DL,
        ST_MUL_DR,
        ST_MUL_FL,
        ST_MUL_FR,
        ST_MUL_ML,
        ST_MUL_MR,
        ST_FIN
    } state_t;

    state_t state_reg;

    coef_t mix_level_reg, room_feedback_reg, damping_reg;

    logic [AW-1:0] pos_reg;
    logic [AW:0]   fill_reg;
    logic          near_ok_reg;

    sample_t l_reg, r_reg, mono_reg;
    sample_t near_l_reg, near_r_reg;
    sample_t filt_l_reg, filt_r_reg;
    sample_t out_l_reg;
    sample_t m_left_reg, m_right_reg;
    logic    m_tvalid_reg;

    logic signed [33:0] prod_reg;

    sample_t mem_l [DELAY_LENGTH];
    sample_t mem_r [DELAY_LENGTH];
    sample_t rdata_l_reg, rdata_r_reg;

    logic [AW:0]   far_sum;
    logic [AW-1:0] far_pos;
    logic          far_ok;
    logic [AW-1:0] rd_addr;
    sample_t       far_l, far_r;

    logic signed [16:0] mul_a;
    coef_t              mul_w;
    logic signed [33:0] mul_p;
    logic signed [17:0] rnd;

    logic               in_beat;
    logic               cfg_wr;
    logic [1:0]         cfg_idx;
    logic signed [16:0] in_sum;
    logic               out_free;

    assign in_beat  = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {m_right_reg, m_left_reg};
    assign out_free = !m_tvalid_reg || m_tready;

    assign pready  = 1'b1;
    assign cfg_idx = paddr[3:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb begin
        unique case (cfg_idx)
            REG_MIX_LEVEL:     prdata = {16'd0, mix_level_reg};
            REG_ROOM_FEEDBACK: prdata = {16'd0, room_feedback_reg};
            REG_DAMPING:       prdata = {16'd0, damping_reg};
            default:           prdata = '0;
        endcase
    end

    assign in_sum = {s_tdata[15], s_tdata[15:0]} + {s_tdata[31], s_tdata[31:16]};

    // Far tap sits half a line ahead of the write position.
    assign far_sum = {1'b0, pos_reg} + HALF_W;
    assign far_pos = (far_sum >= LEN_W) ? AW'(far_sum - LEN_W) : far_sum[AW-1:0];
    assign far_ok  = ({1'b0, far_pos} < fill_reg);
    assign rd_addr = (state_reg == ST_IDLE) ? pos_reg : far_pos;
    assign far_l   = far_ok ? rdata_l_reg : '0;
    assign far_r   = far_ok ? rdata_r_reg : '0;

    always_comb begin
        mul_a = '0;
        mul_w = '0;
        unique case (state_reg)
            ST_MUL_DL: begin
                mul_a = {far_l[15], far_l} - {near_l_reg[15], near_l_reg};
                mul_w = damping_reg;
            end
            ST_MUL_DR: begin
                mul_a = {far_r[15], far_r} - {near_r_reg[15], near_r_reg};
                mul_w = damping_reg;
            end
            ST_MUL_FL: begin
                mul_a = {filt_l_reg[15], filt_l_reg};
                mul_w = room_feedback_reg;
            end
            ST_MUL_FR: begin
                mul_a = {filt_r_reg[15], filt_r_reg};
                mul_w = room_feedback_reg;
            end
            ST_MUL_ML: begin
                mul_a = {near_l_reg[15], near_l_reg} - {l_reg[15], l_reg};
                mul_w = mix_level_reg;
            end
            ST_MUL_MR: begin
                mul_a = {near_r_reg[15], near_r_reg} - {r_reg[15], r_reg};
                mul_w = mix_level_reg;
            end
            default: begin
                mul_a = '0;
                mul_w = '0;
            end
        endcase
    end

    assign mul_p = 34'(mul_a) * $signed({18'd0, mul_w});
    assign rnd   = round16(prod_reg);

    always_ff @(posedge aclk) begin
        rdata_l_reg <= mem_l[rd_addr];
        rdata_r_reg <= mem_r[rd_addr];
        if (state_reg == ST_MUL_FR) begin
            mem_l[pos_reg] <= add_sat(mono_reg, rnd);
        end
        if (state_reg == ST_MUL_ML) begin
            mem_r[pos_reg] <= add_sat(mono_reg, rnd);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg         <= ST_IDLE;
            mix_level_reg     <= MIX_LEVEL_RESET;
            room_feedback_reg <= ROOM_FEEDBACK_RESET;
            damping_reg       <= DAMPING_RESET;
            pos_reg           <= '0;
            fill_reg          <= '0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (cfg_idx)
                    REG_MIX_LEVEL:     mix_level_reg     <= pwdata[15:0];
                    REG_ROOM_FEEDBACK: room_feedback_reg <= pwdata[15:0];
                    REG_DAMPING:       damping_reg       <= pwdata[15:0];
                    default: ;
                endcase
            end

            if (m_tvalid_reg && m_tready && state_reg != ST_FIN) begin
                m_tvalid_reg <= 1'b0;
            end

            // hold the last product while the finishing step waits
            if (state_reg != ST_FIN) begin
                prod_reg <= mul_p;
            end

            unique case (state_reg)
                ST_IDLE: begin
                    if (in_beat) begin
                        l_reg       <= s_tdata[15:0];
                        r_reg       <= s_tdata[31:16];
                        mono_reg    <= in_sum[16:1];
                        near_ok_reg <= ({1'b0, pos_reg} < fill_reg);
                        state_reg   <= ST_RD_FAR;
                    end
                end
                ST_RD_FAR: begin
                    near_l_reg <= near_ok_reg ? rdata_l_reg : '0;
                    near_r_reg <= near_ok_reg ? rdata_r_reg : '0;
                    state_reg  <= ST_MUL_DL;
                end
                ST_MUL_DL: begin
                    state_reg <= ST_MUL_DR;
                end
                ST_MUL_DR: begin
                    filt_l_reg <= add_sat(near_l_reg, rnd);
                    state_reg  <= ST_MUL_FL;
                end
                ST_MUL_FL: begin
                    filt_r_reg <= add_sat(near_r_reg, rnd);
                    state_reg  <= ST_MUL_FR;
                end
                ST_MUL_FR: begin
                    state_reg <= ST_MUL_ML;
                end
                ST_MUL_ML: begin
                    pos_reg <= (pos_reg == AW'(DELAY_LENGTH - 1)) ? '0 : pos_reg + 1'b1;
                    if (fill_reg != LEN_W) begin
                        fill_reg <= fill_reg + 1'b1;
                    end
                    state_reg <= ST_MUL_MR;
                end
                ST_MUL_MR: begin
                    out_l_reg <= add_sat(l_reg, rnd);
                    state_reg <= ST_FIN;
                end
                ST_FIN: begin
                    if (out_free) begin
                        m_left_reg   <= out_l_reg;
                        m_right_reg  <= add_sat(r_reg, rnd);
                        m_tvalid_reg <= 1'b1;
                        state_reg    <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/stereo_damped_comb_reverb_checker.sv
`timescale 1ns / 1ps
// Watches the reverb's stream and register ports, predicts each output pair and compares.
module stereo_damped_comb_reverb_checker
    import sdcr_pkg::*;
#(
    parameter int unsigned DELAY_LENGTH = 1000
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [31:0]           s_tdata,   // [15:0] left_in, [31:16] right_in
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [31:0]           m_tdata,   // [15:0] left_out, [31:16] right_out
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic                  pready,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output int                    failures,
    output int                    pending
);

    typedef struct packed {
        sample_t right;
        sample_t left;
    } pair_t;

    coef_t       mix_q;
    coef_t       room_q;
    coef_t       damp_q;
    sample_t     line_l [DELAY_LENGTH];
    sample_t     line_r [DELAY_LENGTH];
    int unsigned pos_l;
    int unsigned pos_r;
    pair_t       mixed_pairs [$];

    function automatic longint round_q16(longint x);
        return (x + 64'sd32768) >>> 16;
    endfunction

    function automatic sample_t clamp16(longint x);
        if (x > 32767) begin
            return 16'sh7fff;
        end else if (x < -32768) begin
            return 16'sh8000;
        end
        return x[15:0];
    endfunction

    // weight w on b, 65536 - w on a
    function automatic longint weigh(longint a, longint b, coef_t w);
        return round_q16((64'sd65536 - longint'(w)) * a + longint'(w) * b);
    endfunction

    function automatic sample_t comb_write(sample_t near_s, sample_t far_s, longint drive);
        return clamp16(drive + round_q16(longint'(room_q) * weigh(near_s, far_s, damp_q)));
    endfunction

    task automatic advance_reverb(input sample_t left_dry, input sample_t right_dry,
                                  output pair_t mixed);
        longint  mono;
        sample_t wet_l;
        sample_t wet_r;
        mono = (longint'(left_dry) + longint'(right_dry)) >>> 1;
        wet_l = line_l[pos_l];
        line_l[pos_l] = comb_write(wet_l, line_l[(pos_l + DELAY_LENGTH / 2) % DELAY_LENGTH],
                                   mono);
        pos_l = (pos_l + 1) % DELAY_LENGTH;
        wet_r = line_r[pos_r];
        line_r[pos_r] = comb_write(wet_r, line_r[(pos_r + DELAY_LENGTH / 2) % DELAY_LENGTH],
                                   mono);
        pos_r = (pos_r + 1) % DELAY_LENGTH;
        mixed.left  = clamp16(weigh(left_dry, wet_l, mix_q));
        mixed.right = clamp16(weigh(right_dry, wet_r, mix_q));
    endtask

    always @(posedge aclk) begin
        pair_t got;
        pair_t want;
        if (!aresetn) begin
            mix_q  = MIX_LEVEL_RESET;
            room_q = ROOM_FEEDBACK_RESET;
            damp_q = DAMPING_RESET;
            for (int i = 0; i < DELAY_LENGTH; i++) begin
                line_l[i] = '0;
                line_r[i] = '0;
            end
            pos_l = 0;
            pos_r = 0;
            mixed_pairs.delete();
            failures = 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata;
                if (mixed_pairs.size() == 0) begin
                    if (failures < 10) begin
                        $display("%0t: unexpected output beat left %0d right %0d",
                                 $realtime, got.left, got.right);
                    end
                    failures++;
                end else begin
                    want = mixed_pairs.pop_front();
                    if (got.left !== want.left || got.right !== want.right) begin
                        if (failures < 10) begin
                            $display("%0t: output mismatch: expected left %0d right %0d, got left %0d right %0d",
                                     $realtime, want.left, want.right, got.left, got.right);
                        end
                        failures++;
                    end
                end
            end
            if (psel && penable && pwrite && pready) begin
                case (paddr[CFG_ADDR_W-1:2])
                    REG_MIX_LEVEL:     mix_q  = pwdata[15:0];
                    REG_ROOM_FEEDBACK: room_q = pwdata[15:0];
                    REG_DAMPING:       damp_q = pwdata[15:0];
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready) begin
                advance_reverb(s_tdata[15:0], s_tdata[31:16], want);
                mixed_pairs.push_back(want);
            end
        end
        pending = mixed_pairs.size();
    end

endmodule

FILE: sim/stereo_damped_comb_reverb_tb.sv
`timescale 1ns / 1ps
// Testbench top for the stereo comb reverb: clock, reset, stimulus, register writes and verdict.
module stereo_damped_comb_reverb_tb
    import sdcr_pkg::*;
();

    localparam int unsigned DELAY_LENGTH = 1000;
    localparam int unsigned IDLE_LIMIT   = 4000;
    localparam int unsigned LONG_HOLD    = 400;
    localparam int unsigned DRAIN_CYCLES = 32;
    localparam logic [1:0]  REG_SPARE    = 2'd3;

    typedef enum {FILL_RANDOM, FILL_LOUD, FILL_QUIET, FILL_EXTREME} fill_t;

    logic                  aclk = 1'b0;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [31:0]           s_tdata;   // [15:0] left_in, [31:16] right_in
    logic                  m_tvalid;
    logic                  m_tready;
    logic [31:0]           m_tdata;   // [15:0] left_out, [31:16] right_out
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;
    int                    failures;
    int                    pending;
    bit                    calm;
    bit                    hold_now;
    bit                    long_hold_done;
    int unsigned           quiet_cycles = 0;

    always #2 aclk = ~aclk;

    stereo_damped_comb_reverb #(.DELAY_LENGTH(DELAY_LENGTH)) dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    stereo_damped_comb_reverb_checker #(.DELAY_LENGTH(DELAY_LENGTH)) u_check (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .psel(psel), .penable(penable), .pwrite(pwrite), .pready(pready),
        .paddr(paddr), .pwdata(pwdata),
        .failures(failures), .pending(pending)
    );

    function automatic sample_t draw_sample(fill_t mode, bit negative);
        case (mode)
            FILL_LOUD: begin
                if (negative) begin
                    return sample_t'(32'h8000 + $urandom_range(0, 255));
                end
                return sample_t'(32'h7fff - $urandom_range(0, 255));
            end
            FILL_QUIET: return sample_t'(int'($urandom_range(0, 511)) - 256);
            FILL_EXTREME: begin
                case ($urandom_range(0, 4))
                    0: return 16'sh7fff;
                    1: return 16'sh8000;
                    2: return 16'sh0000;
                    3: return 16'shffff;
                    default: return 16'sh0001;
                endcase
            end
            default: return sample_t'($urandom);
        endcase
    endfunction

    // start at a falling edge, return at the falling edge after the beat
    task automatic send_pair(sample_t left_dry, sample_t right_dry);
        s_tvalid <= 1'b1;
        s_tdata  <= {right_dry, left_dry};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic run_phase(int unsigned count, fill_t mode, bit steady);
        bit negative;
        for (int unsigned i = 0; i < count; i++) begin
            negative = ((i / 100) % 2) == 1;
            if (!calm && !steady && $urandom_range(0, 4) == 0) begin
                s_tvalid <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end
            send_pair(draw_sample(mode, negative), draw_sample(mode, negative));
        end
    endtask

    task automatic write_reg(logic [1:0] index, logic [15:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {16'($urandom), value};
        @(negedge aclk);
        penable <= 1'b1;
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(negedge aclk);
    endtask

    task automatic settle_and_write(coef_t mix, coef_t room, coef_t damp);
        s_tvalid <= 1'b0;
        wait (pending == 0);
        @(negedge aclk);
        write_reg(REG_MIX_LEVEL, mix);
        write_reg(REG_ROOM_FEEDBACK, room);
        write_reg(REG_DAMPING, damp);
    endtask

    // receiver: random stalls, one long hold on request, none once calm
    initial begin
        m_tready = 1'b0;
        long_hold_done = 1'b0;
        wait (aresetn);
        forever begin
            if (hold_now && !long_hold_done) begin
                long_hold_done = 1'b1;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge aclk);
            end else if (!calm && $urandom_range(0, 3) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 13)) @(negedge aclk);
            end else begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(negedge aclk);
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles == IDLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        aresetn  = 1'b0;
        s_tvalid = 1'b0;
        s_tdata  = '0;
        psel     = 1'b0;
        penable  = 1'b0;
        pwrite   = 1'b0;
        paddr    = '0;
        pwdata   = '0;
        calm     = 1'b0;
        hold_now = 1'b0;
        repeat (8) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // full-scale corners, odd sums (floor of the mono average), sign mixes
        send_pair(16'sh0000, 16'sh0000);
        send_pair(16'sh7fff, 16'sh7fff);
        send_pair(16'sh8000, 16'sh8000);
        send_pair(16'sh7fff, 16'sh8000);
        send_pair(16'sh8000, 16'sh7fff);
        send_pair(16'shffff, 16'sh0000);
        send_pair(16'sh0000, 16'shffff);
        send_pair(16'sh0001, 16'sh0000);
        send_pair(16'shffff, 16'shffff);
        send_pair(16'sh8000, 16'sh0000);
        send_pair(16'sh0000, 16'sh7fff);
        send_pair(16'sh0001, 16'sh0001);
        send_pair(16'sh8001, 16'sh7ffe);
        send_pair(16'sh5555, 16'shaaaa);
        send_pair(16'shaaaa, 16'sh5555);
        send_pair(16'sh1234, 16'shedcb);

        settle_and_write(16'd0, 16'd65535, 16'd0);
        write_reg(REG_SPARE, 16'($urandom));
        run_phase(300, FILL_RANDOM, 1'b0);

        // push the comb into saturation both ways
        settle_and_write(16'd65535, 16'd65535, 16'd65535);
        run_phase(300, FILL_LOUD, 1'b0);

        settle_and_write(16'd32768, 16'd0, 16'd32768);
        run_phase(150, FILL_QUIET, 1'b0);
        run_phase(150, FILL_EXTREME, 1'b0);

        // long output hold while input keeps coming
        settle_and_write(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
        hold_now = 1'b1;
        run_phase(300, FILL_RANDOM, 1'b1);

        settle_and_write(16'd1, 16'd65535, 16'd1);
        run_phase(200, FILL_LOUD, 1'b0);

        settle_and_write(coef_t'($urandom), coef_t'($urandom), coef_t'($urandom));
        calm = 1'b1;
        run_phase(300, FILL_RANDOM, 1'b0);

        s_tvalid <= 1'b0;
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (failures == 0 && pending == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
